// File: design/assert_macros.svh
// Assertion macros used by the scorer top level.
// Include with the bare file name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// File: design/mswsc_pkg.sv
// Shared types and constants for the Markov site window scorer.
// No dependencies; used by mswsc_cell and the top level.
package mswsc_pkg;

   localparam int WEIGHT_W = 16;
   localparam int SCORE_W  = 24;
   localparam int BASE_W   = 3;

   // Highest known base code (T); anything above is unknown
   localparam logic [BASE_W-1:0] BASE_LAST = 3'd3;

   // Per-cell control from the top level
   typedef struct packed {
      logic shift_en;   // push beat: take the neighbor's base
      logic active;     // cell position lies inside the window
   } cell_ctl_type;

   // Forward and reverse partial sums handed along the chain
   typedef struct packed {
      logic [SCORE_W-1:0] fwd;
      logic [SCORE_W-1:0] rev;
   } score_pair_type;

endpackage

// File: design/mswsc_cell.sv
// One window position of the scorer chain: base history slot, context
// recurrences, local weight memory and partial-sum stage. Uses mswsc_pkg.
module mswsc_cell #(
   parameter int CTX_W = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mswsc_pkg::cell_ctl_type           ctl,
   input  logic [mswsc_pkg::BASE_W-1:0]      hist_left,
   output logic [mswsc_pkg::BASE_W-1:0]      hist_q,
   input  logic [mswsc_pkg::BASE_W-1:0]      fwd_base,
   input  logic [CTX_W-1:0]                  ctx_mask,
   input  logic [CTX_W-1:0]                  fctx_left,
   input  logic [CTX_W-1:0]                  rctx_left,
   output logic [CTX_W-1:0]                  fctx_q,
   output logic [CTX_W-1:0]                  rctx_q,
   input  mswsc_pkg::score_pair_type         psum_left,
   output mswsc_pkg::score_pair_type         psum_q,
   input  logic                              wr_en,
   input  logic [CTX_W-1:0]                  wr_addr,
   input  logic [mswsc_pkg::WEIGHT_W-1:0]    wr_data
);

   localparam int DEPTH = 1 << CTX_W;
   localparam int EXT_W = mswsc_pkg::SCORE_W - mswsc_pkg::WEIGHT_W;

   logic [mswsc_pkg::BASE_W-1:0]   hist_ff, hist_in;
   logic [mswsc_pkg::BASE_W-1:0]   fbase_ff;
   logic [CTX_W-1:0]               fctx_ff, fctx_in;
   logic [CTX_W-1:0]               rctx_ff, rctx_in;
   logic [mswsc_pkg::WEIGHT_W-1:0] fwd_w_ff, rev_w_ff;
   mswsc_pkg::score_pair_type      psum_ff, psum_in;
   logic [1:0]                     fdigit, rdigit;
   logic [mswsc_pkg::SCORE_W-1:0]  fwd_add, rev_add;

   logic [mswsc_pkg::WEIGHT_W-1:0] wmem [DEPTH];

   // history slot: shifts one place on each push beat
   always_comb begin
      hist_in = ctl.shift_en ? hist_left : hist_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
      end else begin
         hist_ff <= hist_in;
      end
   end

   // digits: unknown bases count as A on both strands, no complement
   always_comb begin
      fdigit = (fbase_ff > mswsc_pkg::BASE_LAST) ? 2'd0 : fbase_ff[1:0];
      rdigit = (hist_ff > mswsc_pkg::BASE_LAST) ? 2'd0 :
               2'(mswsc_pkg::BASE_LAST[1:0] - hist_ff[1:0]);
   end

   // context recurrence from the left neighbor, newest digit in the low bits
   always_comb begin
      fctx_in = CTX_W'({fctx_left, 2'b00}) | CTX_W'(fdigit);
      fctx_in = fctx_in & ctx_mask;
      rctx_in = CTX_W'({rctx_left, 2'b00}) | CTX_W'(rdigit);
      rctx_in = rctx_in & ctx_mask;
   end

   always_ff @(posedge clock) begin
      fbase_ff <= fwd_base;
      fctx_ff  <= fctx_in;
      rctx_ff  <= rctx_in;
   end

   // weight memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         wmem[wr_addr] <= wr_data;
      end
      fwd_w_ff <= wmem[fctx_ff];
      rev_w_ff <= wmem[rctx_ff];
   end

   // partial sums: positions outside the window add nothing
   always_comb begin
      fwd_add = ctl.active ? {{EXT_W{fwd_w_ff[mswsc_pkg::WEIGHT_W-1]}}, fwd_w_ff} : '0;
      rev_add = ctl.active ? {{EXT_W{rev_w_ff[mswsc_pkg::WEIGHT_W-1]}}, rev_w_ff} : '0;
      psum_in.fwd = psum_left.fwd + fwd_add;
      psum_in.rev = psum_left.rev + rev_add;
   end

   always_ff @(posedge clock) begin
      psum_ff <= psum_in;
   end

   assign hist_q = hist_ff;
   assign fctx_q = fctx_ff;
   assign rctx_q = rctx_ff;
   assign psum_q = psum_ff;

endmodule

// File: design/markov_site_window_scorer_unit.sv
// Top level of the Markov site window scorer: request decode, register
// port, chain of mswsc_cell stages and result register. Uses mswsc_pkg.
// A load beat (cmd 0) writes one weight and gives no result. A push beat
// (cmd 1) shifts the base into the chain; its scores reach the result
// register once the contexts have settled cell by cell, each cell has read
// its own weight memory, and the partial sums have walked the whole chain
// one cell per cycle. The request side stalls during that walk and until the
// result register is free; once the scores sit in the result register the
// next beat is accepted while the result waits to be taken.
// No clearing pass: weights read before they are loaded are undefined.
`include "assert_macros.svh"

module markov_site_window_scorer_unit #(
   parameter int MAX_WIDTH   = 32,
   parameter int ORDER_LIMIT = 2
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_cmd,
   input  logic [2:0]                          req_base_code,
   input  logic [4:0]                          req_load_position,
   input  logic [5:0]                          req_load_context,
   input  logic signed [15:0]                  req_load_weight,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [23:0]                  rsp_forward_score,
   output logic signed [23:0]                  rsp_reverse_score,
   output logic                                rsp_window_full,
   // register write port
   input  logic                                csr_we,
   input  logic [1:0]                          csr_index,
   input  logic [5:0]                          csr_wdata
);

   localparam int CTX_W      = 2 * (ORDER_LIMIT + 1);
   localparam int FW         = $clog2(MAX_WIDTH + 1);
   localparam int FW1        = FW + 1;
   localparam int HIST_IDX_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int LAST       = MAX_WIDTH + 3;
   localparam int CNT_W      = $clog2(LAST + 1);

   localparam logic [1:0] CSR_WINDOW_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_CONTEXT_ORDER = 2'd1;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_PUSH = 1'b1;

   logic [5:0]       ww_ff, ww_in;
   logic [1:0]       ord_ff, ord_in;
   logic [FW-1:0]    fill_ff, fill_in;
   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [mswsc_pkg::SCORE_W-1:0] rsp_fwd_ff, rsp_rev_ff;
   logic             rsp_full_ff;

   logic [FW-1:0]    w_eff;
   logic [2:0]       ord_eff;
   logic [CTX_W-1:0] ctx_mask;
   logic             req_acc, push_acc, load_acc, capture, at_last;
   logic [CTX_W-1:0] wr_addr;

   logic [mswsc_pkg::BASE_W-1:0] hist_q  [MAX_WIDTH];
   logic [mswsc_pkg::BASE_W-1:0] hist_l  [MAX_WIDTH];
   logic [mswsc_pkg::BASE_W-1:0] fbase   [MAX_WIDTH];
   logic [CTX_W-1:0]             fctx_q  [MAX_WIDTH];
   logic [CTX_W-1:0]             rctx_q  [MAX_WIDTH];
   logic [CTX_W-1:0]             fctx_l  [MAX_WIDTH];
   logic [CTX_W-1:0]             rctx_l  [MAX_WIDTH];
   mswsc_pkg::score_pair_type    psum_q  [MAX_WIDTH];
   mswsc_pkg::score_pair_type    psum_l  [MAX_WIDTH];
   mswsc_pkg::cell_ctl_type      ctl     [MAX_WIDTH];
   logic                         wr_en   [MAX_WIDTH];

   // handshake decode
   assign req_stall = busy_ff;
   assign req_acc   = req_valid && !req_stall;
   assign push_acc  = req_acc && (req_cmd == REQ_PUSH);
   assign load_acc  = req_acc && (req_cmd == REQ_LOAD);
   assign wr_addr   = CTX_W'(req_load_context);

   // register port
   always_comb begin
      ww_in  = ww_ff;
      ord_in = ord_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_WINDOW_WIDTH:  ww_in  = csr_wdata;
            CSR_CONTEXT_ORDER: ord_in = csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // effective width and order, clamped to the built range
   always_comb begin
      if (ww_ff == 6'd0) begin
         w_eff = FW'(1);
      end else if (7'({1'b0, ww_ff}) > 7'(MAX_WIDTH)) begin
         w_eff = FW'(MAX_WIDTH);
      end else begin
         w_eff = FW'(ww_ff);
      end
      if ({1'b0, ord_ff} > 3'(ORDER_LIMIT)) begin
         ord_eff = 3'(ORDER_LIMIT);
      end else begin
         ord_eff = {1'b0, ord_ff};
      end
   end

   // context mask: keep order+1 digits
   for (genvar k = 0; k < CTX_W; k++) begin : g_mask
      localparam int DIGIT = k / 2;
      assign ctx_mask[k] = (3'(DIGIT) <= ord_eff);
   end

   // push sequencer: walk count while the sums travel the chain
   assign at_last = (cnt_ff == CNT_W'(LAST));
   assign capture = busy_ff && at_last && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      fill_in = fill_ff;
      if (push_acc) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         if (fill_ff < FW'(MAX_WIDTH)) begin
            fill_in = fill_ff + FW'(1);
         end
      end else if (busy_ff) begin
         if (at_last) begin
            if (capture) begin
               busy_in = 1'b0;
            end
         end else begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end
      rsp_valid_in = capture || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ww_ff        <= 6'd32;
         ord_ff       <= 2'd0;
         fill_ff      <= '0;
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ww_ff        <= ww_in;
         ord_ff       <= ord_in;
         fill_ff      <= fill_in;
         busy_ff      <= busy_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (capture) begin
         rsp_fwd_ff  <= psum_q[MAX_WIDTH-1].fwd;
         rsp_rev_ff  <= psum_q[MAX_WIDTH-1].rev;
         rsp_full_ff <= (fill_ff >= w_eff);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_forward_score = rsp_fwd_ff;
   assign rsp_reverse_score = rsp_rev_ff;
   assign rsp_window_full   = rsp_full_ff;

   // cell chain
   for (genvar p = 0; p < MAX_WIDTH; p++) begin : g_cell
      logic [HIST_IDX_W-1:0] fidx;

      // window position p reads the base w-1-p slots back
      always_comb begin
         ctl[p].shift_en = push_acc;
         ctl[p].active   = (FW1'(p) < FW1'(w_eff));
         fidx            = HIST_IDX_W'(FW'(w_eff - FW'(1) - FW'(p)));
         fbase[p]        = ctl[p].active ? hist_q[fidx] : '0;
         // load positions above the chain match no cell
         wr_en[p]        = load_acc && (7'({2'b00, req_load_position}) == 7'(p));
      end

      if (p == 0) begin : g_head
         assign hist_l[p] = req_base_code;
         assign fctx_l[p] = '0;
         assign rctx_l[p] = '0;
         assign psum_l[p] = '0;
      end else begin : g_link
         assign hist_l[p] = hist_q[p-1];
         assign fctx_l[p] = fctx_q[p-1];
         assign rctx_l[p] = rctx_q[p-1];
         assign psum_l[p] = psum_q[p-1];
      end

      mswsc_cell #(
         .CTX_W (CTX_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl[p]),
         .hist_left (hist_l[p]),
         .hist_q    (hist_q[p]),
         .fwd_base  (fbase[p]),
         .ctx_mask  (ctx_mask),
         .fctx_left (fctx_l[p]),
         .rctx_left (rctx_l[p]),
         .fctx_q    (fctx_q[p]),
         .rctx_q    (rctx_q[p]),
         .psum_left (psum_l[p]),
         .psum_q    (psum_q[p]),
         .wr_en     (wr_en[p]),
         .wr_addr   (wr_addr),
         .wr_data   (req_load_weight)
      );
   end

   // checks
   `ASSERT_NEXT(a_push_starts_walk, clock, reset, push_acc, busy_ff && (cnt_ff == '0))
   `ASSERT_IMPLIES(a_rsp_from_last, clock, reset, rsp_valid_ff && !$past(rsp_valid_ff), $past(capture))
   `ASSERT_IMPLIES(a_hist_frozen, clock, reset, busy_ff && $past(busy_ff), $stable(hist_q[0]))
   `ASSERT_IMPLIES(a_fill_bound, clock, reset, 1'b1, fill_ff <= FW'(MAX_WIDTH))

endmodule

// File: tb/testbench.sv
// Self-checking testbench for markov_site_window_scorer_unit: weight loads and
// base pushes under random gaps and result stalls, scores checked per push.
// Depends on mswsc_pkg and the scorer RTL only.
`timescale 1ns / 1ps

module testbench;

   localparam int BASE_W   = mswsc_pkg::BASE_W;
   localparam int WEIGHT_W = mswsc_pkg::WEIGHT_W;
   localparam int SCORE_W  = mswsc_pkg::SCORE_W;
   localparam logic [BASE_W-1:0] BASE_LAST = mswsc_pkg::BASE_LAST;

   localparam int MAX_WIDTH = 32;
   localparam int ORDER_LIMIT = 2;
   localparam int CTX_SPAN = 4 << (2 * ORDER_LIMIT);
   // contexts reachable at order 0 and at order 1
   localparam int CTX0_SPAN = 4;
   localparam int CTX1_SPAN = 16;
   // widest window used with order 1 and with order 2; only that much is preloaded
   localparam int ORDER1_WIDTH = 8;
   localparam int ORDER2_WIDTH = 5;
   // settle past the time a push takes to walk the chain
   localparam int SETTLE_CYCLES = MAX_WIDTH + 8;
   localparam int TIMEOUT_NS = 25_000_000;

   // request commands
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_PUSH = 1'b1;

   // register indexes; the upper two are unmapped
   localparam logic [1:0] REG_WINDOW_WIDTH = 2'd0;
   localparam logic [1:0] REG_CONTEXT_ORDER = 2'd1;
   localparam logic [1:0] REG_SPARE_A = 2'd2;
   localparam logic [1:0] REG_SPARE_B = 2'd3;

   localparam logic [BASE_W-1:0] BASE_A = 3'd0;
   localparam logic [BASE_W-1:0] BASE_UNKNOWN = 3'd4;

   // order 0 contexts of A on the forward strand and of its complement
   localparam logic [5:0] CTX_A = 6'd0;
   localparam logic [5:0] CTX_T = 6'd3;

   localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = 16'sh8000;
   localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = 16'sh7FFF;

   typedef struct packed {
      logic                       cmd;
      logic [BASE_W-1:0]          base_code;
      logic [4:0]                 load_position;
      logic [5:0]                 load_context;
      logic signed [WEIGHT_W-1:0] load_weight;
   } scan_beat_type;

   typedef struct {
      logic signed [SCORE_W-1:0] fwd;
      logic signed [SCORE_W-1:0] rev;
      logic                      full;
   } window_score_type;

   // Scorer model plus the queue of scores still owed by the block
   class scoreboard_type;
      logic signed [WEIGHT_W-1:0] weight_mem [MAX_WIDTH][CTX_SPAN];
      logic [BASE_W-1:0] history [MAX_WIDTH];
      int unsigned fill;
      int unsigned width_reg;
      int unsigned order_reg;
      window_score_type owed_q[$];
      int errors;

      function new();
         foreach (weight_mem[i, j]) weight_mem[i][j] = '0;
         foreach (history[i]) history[i] = BASE_A;
         fill = 0;
         width_reg = MAX_WIDTH;
         order_reg = 0;
         errors = 0;
      endfunction

      function void write_register(logic [1:0] idx, logic [5:0] value);
         if (idx == REG_WINDOW_WIDTH) width_reg = value;
         else if (idx == REG_CONTEXT_ORDER) order_reg = value[1:0];
      endfunction

      function int pending();
         return owed_q.size();
      endfunction

      // Accepted request beat: a load updates the table, a push owes a score
      function void note_beat(scan_beat_type b);
         int unsigned w, ord, mask, ctx, code;
         int fwd, rev;
         window_score_type want;
         if (b.cmd == CMD_LOAD) begin
            weight_mem[b.load_position][b.load_context] = b.load_weight;
            return;
         end
         for (int k = MAX_WIDTH - 1; k > 0; k--) history[k] = history[k - 1];
         history[0] = b.base_code;
         if (fill < MAX_WIDTH) fill++;
         w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
         ord = (order_reg > ORDER_LIMIT) ? ORDER_LIMIT : order_reg;
         mask = (4 << (2 * ord)) - 1;
         // forward: oldest base first, unknown reads as A
         ctx = 0;
         fwd = 0;
         for (int p = 0; p < w; p++) begin
            code = history[w - 1 - p];
            if (code > BASE_LAST) code = 0;
            ctx = ((ctx << 2) + code) & mask;
            fwd += weight_mem[p][ctx];
         end
         // reverse complement: newest first, unknown is not complemented
         ctx = 0;
         rev = 0;
         for (int p = 0; p < w; p++) begin
            code = history[p];
            code = (code > BASE_LAST) ? 0 : BASE_LAST - code;
            ctx = ((ctx << 2) + code) & mask;
            rev += weight_mem[p][ctx];
         end
         want.fwd = fwd[SCORE_W-1:0];
         want.rev = rev[SCORE_W-1:0];
         want.full = (fill >= w);
         owed_q.push_back(want);
      endfunction

      task report_mismatch(string msg);
         errors++;
         $display("%0t: %s", $time, msg);
      endtask

      task check_score(logic signed [SCORE_W-1:0] fwd, logic signed [SCORE_W-1:0] rev,
                       logic full);
         window_score_type want;
         if (owed_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result fwd %0d rev %0d", fwd, rev));
            return;
         end
         want = owed_q.pop_front();
         if (fwd !== want.fwd)
            report_mismatch($sformatf("forward_score %0d, want %0d", fwd, want.fwd));
         if (rev !== want.rev)
            report_mismatch($sformatf("reverse_score %0d, want %0d", rev, want.rev));
         if (full !== want.full)
            report_mismatch($sformatf("window_full %0b, want %0b", full, want.full));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   scan_beat_type req_beat = '0;
   logic req_stall;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [SCORE_W-1:0] rsp_forward_score;
   logic signed [SCORE_W-1:0] rsp_reverse_score;
   logic rsp_window_full;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = '0;
   logic [5:0] csr_wdata = '0;

   bit idle_calm = 1'b0;
   bit stall_calm = 1'b0;
   int stall_left = 0;
   scoreboard_type sb;

   markov_site_window_scorer_unit #(
      .MAX_WIDTH(MAX_WIDTH),
      .ORDER_LIMIT(ORDER_LIMIT)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_beat.cmd),
      .req_base_code(req_beat.base_code),
      .req_load_position(req_beat.load_position),
      .req_load_context(req_beat.load_context),
      .req_load_weight(req_beat.load_weight),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_forward_score(rsp_forward_score),
      .rsp_reverse_score(rsp_reverse_score),
      .rsp_window_full(rsp_window_full),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("markov_site_window_scorer_unit regression: fail");
      $finish;
   end

   // Result side back-pressure: mostly short stalls, now and then a long one
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (!stall_calm && $urandom_range(0, 99) < 25) begin
         rsp_stall <= 1'b1;
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                  : $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitors: register writes, accepted request beats, accepted results
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) sb.write_register(csr_index, csr_wdata);
         if (req_valid && !req_stall) sb.note_beat(req_beat);
         if (rsp_valid && !rsp_stall)
            sb.check_score(rsp_forward_score, rsp_reverse_score, rsp_window_full);
      end
   end

   function automatic int pick_gap();
      int r;
      if (idle_calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic scan_beat_type make_beat(logic cmd, logic [BASE_W-1:0] code,
                                               logic [4:0] pos, logic [5:0] ctx,
                                               logic signed [WEIGHT_W-1:0] wt);
      scan_beat_type b;
      b.cmd = cmd;
      b.base_code = code;
      b.load_position = pos;
      b.load_context = ctx;
      b.load_weight = wt;
      return b;
   endfunction

   // Every field random; the command decides which fields matter
   function automatic scan_beat_type rand_beat(int push_pct);
      scan_beat_type b;
      int r;
      b.cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_LOAD;
      b.base_code = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, BASE_LAST))
                                                 : 3'($urandom_range(BASE_UNKNOWN, 7));
      b.load_position = 5'($urandom_range(0, MAX_WIDTH - 1));
      b.load_context = 6'($urandom_range(0, CTX_SPAN - 1));
      r = $urandom_range(0, 99);
      if (r < 10) b.load_weight = WEIGHT_MIN;
      else if (r < 20) b.load_weight = WEIGHT_MAX;
      else b.load_weight = 16'($urandom);
      return b;
   endfunction

   // Starts right after the clock rises; returns once the block has taken the beat
   task automatic send_beat(input scan_beat_type b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_beat <= b;
      do @(posedge clock); while (req_stall);
   endtask

   // Caller has already dropped valid
   task automatic drain();
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [5:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_random(input int pos, input int ctx);
      send_beat(make_beat(CMD_LOAD, 3'($urandom_range(0, 7)), 5'(pos), 6'(ctx),
                          16'($urandom)));
   endtask

   // Order 0, full width: one weight on the contexts that A and unknown bases
   // reach, then enough of those bases to flush the whole window
   task automatic extreme_pass(input logic signed [WEIGHT_W-1:0] wt);
      logic [BASE_W-1:0] code;
      for (int pos = 0; pos < MAX_WIDTH; pos++) begin
         send_beat(make_beat(CMD_LOAD, BASE_A, 5'(pos), CTX_A, wt));
         send_beat(make_beat(CMD_LOAD, BASE_A, 5'(pos), CTX_T, wt));
      end
      for (int i = 0; i < MAX_WIDTH + 2; i++) begin
         code = ($urandom_range(0, 3) == 0) ? BASE_A : 3'($urandom_range(BASE_UNKNOWN, 7));
         send_beat(make_beat(CMD_PUSH, code, 5'd0, 6'd0, 16'sd0));
      end
      req_valid <= 1'b0;
   endtask

   task automatic run_phase(input logic [5:0] width_val, input logic [5:0] order_val,
                            input int beats, input bit calm, input bit hold_mid);
      drain();
      write_reg(REG_WINDOW_WIDTH, width_val);
      write_reg(REG_CONTEXT_ORDER, order_val);
      idle_calm = calm;
      stall_calm = calm;
      for (int i = 0; i < beats; i++) begin
         // hold off the sender until every owed score is back
         if (hold_mid && i == beats / 2) begin
            req_valid <= 1'b0;
            drain();
         end
         send_beat(rand_beat(80));
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      logic [5:0] ord_pick;
      logic [5:0] wid_pick;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // preload every entry a push can reach: order 0 at any width, order 1 up
      // to ORDER1_WIDTH positions, order 2 up to ORDER2_WIDTH positions
      for (int pos = 0; pos < MAX_WIDTH; pos++)
         for (int ctx = 0; ctx < ((pos < ORDER1_WIDTH) ? CTX1_SPAN : CTX0_SPAN); ctx++)
            load_random(pos, ctx);
      for (int pos = 2; pos < ORDER2_WIDTH; pos++)
         for (int ctx = CTX1_SPAN; ctx < CTX_SPAN; ctx++)
            load_random(pos, ctx);

      // directed: field extremes, window still filling, every base code
      send_beat(make_beat(CMD_LOAD, 3'd7, 5'd0, 6'd0, WEIGHT_MAX));
      send_beat(make_beat(CMD_LOAD, 3'd7, 5'd31, 6'd63, WEIGHT_MIN));
      send_beat(make_beat(CMD_LOAD, BASE_A, 5'd31, 6'd0, WEIGHT_MIN));
      for (int c = 0; c < 8; c++)
         send_beat(make_beat(CMD_PUSH, 3'(c), 5'd31, 6'd63, -16'sd1));
      req_valid <= 1'b0;
      // single-base window, already full
      drain();
      write_reg(REG_WINDOW_WIDTH, 6'd1);
      send_beat(make_beat(CMD_PUSH, 3'd0, 5'd0, 6'd0, 16'sd0));
      send_beat(make_beat(CMD_PUSH, 3'd3, 5'd0, 6'd0, 16'sd0));
      send_beat(make_beat(CMD_PUSH, BASE_UNKNOWN, 5'd0, 6'd0, 16'sd0));
      send_beat(make_beat(CMD_PUSH, 3'd7, 5'd0, 6'd0, 16'sd0));
      send_beat(make_beat(CMD_PUSH, 3'd2, 5'd0, 6'd0, 16'sd0));
      req_valid <= 1'b0;

      // largest magnitude sums: every used weight at one extreme
      run_phase(6'd32, 6'd0, 0, 1'b0, 1'b0);
      extreme_pass(WEIGHT_MIN);
      extreme_pass(WEIGHT_MAX);

      // random phases across register settings, clamped values included
      run_phase(6'd1, 6'd0, 45, 1'b0, 1'b0);
      run_phase(6'd5, 6'd2, 45, 1'b1, 1'b1);
      run_phase(6'd0, 6'd1, 45, 1'b0, 1'b0);
      run_phase(6'd63, 6'd0, 45, 1'b0, 1'b1);
      run_phase(6'd4, 6'd3, 45, 1'b0, 1'b0);
      // unmapped register indexes must leave the settings alone
      drain();
      write_reg(REG_SPARE_A, 6'h3F);
      write_reg(REG_SPARE_B, 6'($urandom_range(0, 63)));
      run_phase(6'd8, 6'd1, 45, 1'b0, 1'b0);
      run_phase(6'd17, 6'd0, 45, 1'b0, 1'b0);
      for (int ph = 0; ph < 3; ph++) begin
         ord_pick = 6'($urandom_range(0, 3));
         if (ord_pick == 6'd0) wid_pick = 6'($urandom_range(0, 63));
         else if (ord_pick == 6'd1) wid_pick = 6'($urandom_range(1, ORDER1_WIDTH));
         else wid_pick = 6'($urandom_range(1, ORDER2_WIDTH));
         run_phase(wid_pick, ord_pick, 45, ($urandom_range(0, 3) == 0), 1'b0);
      end

      // wind down
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("markov_site_window_scorer_unit regression: pass");
      else
         $display("markov_site_window_scorer_unit regression: fail");
      $finish;
   end

endmodule
